>>> design/pulse_width_error_code_decoder_macros.svh
// assertion macros for the pulse width error code decoder
`ifndef PULSE_WIDTH_ERROR_CODE_DECODER_MACROS_SVH
`define PULSE_WIDTH_ERROR_CODE_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PWECD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PWECD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pwecd_pkg.sv
package pwecd_pkg;

  // default widths
  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 8;

  // fixed field widths
  localparam int CFG_BITS  = 16;
  localparam int CODE_BITS = 8;
  localparam int IDX_BITS  = 3;
  // widest threshold in microseconds: (65535 + 1) * 1000 fits in 26 bits
  localparam int THR_BITS  = 26;

  localparam int US_PER_MS = 1000;

  // register reset values in milliseconds
  localparam int START_MIN_MS_RST = 90;
  localparam int START_MAX_MS_RST = 110;
  localparam int CODE_MIN_MS_RST  = 8;
  localparam int CODE_MAX_MS_RST  = 12;
  localparam int TIMEOUT_MS_RST   = 200;
  localparam int HIGHEST_CODE_RST = 7;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] CFG_START_MIN    = 3'd0;
  localparam logic [IDX_BITS-1:0] CFG_START_MAX    = 3'd1;
  localparam logic [IDX_BITS-1:0] CFG_CODE_MIN     = 3'd2;
  localparam logic [IDX_BITS-1:0] CFG_CODE_MAX     = 3'd3;
  localparam logic [IDX_BITS-1:0] CFG_TIMEOUT      = 3'd4;
  localparam logic [IDX_BITS-1:0] CFG_HIGHEST_CODE = 3'd5;

  // input opcodes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // pin levels after an edge
  localparam logic LVL_FALL = 1'b0;
  localparam logic LVL_RISE = 1'b1;

endpackage

>>> design/pulse_width_error_code_decoder.sv
// flow: a transaction accepted into the input register is decoded from there into the
//   output register, where any result that it yields is held while out_stall is high
// throughput: one transaction per cycle; only a stalled full output register holds
//   the input stage
// reset: synchronous active-low rst_n restores register defaults, goes idle and
//   clears the pulse tally and recorded times
module pulse_width_error_code_decoder #(
  parameter int TIME_BITS  = pwecd_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = pwecd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [pwecd_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [pwecd_pkg::CFG_BITS-1:0] cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic                           in_pin_level,
  input  logic [TIME_BITS-1:0]           in_time_us,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pwecd_pkg::CODE_BITS-1:0] out_error_code,
  output logic                           out_well_formed
);

  import pwecd_pkg::*;

  localparam int CMP_BITS = (TIME_BITS > THR_BITS) ? TIME_BITS : THR_BITS;
  localparam int CNT_CMP  = (COUNT_BITS > CODE_BITS) ? COUNT_BITS : CODE_BITS;

  localparam logic [THR_BITS-1:0] START_LO_RST =
    THR_BITS'(START_MIN_MS_RST * US_PER_MS);
  localparam logic [THR_BITS-1:0] START_HI_RST =
    THR_BITS'((START_MAX_MS_RST + 1) * US_PER_MS);
  localparam logic [THR_BITS-1:0] CODE_LO_RST =
    THR_BITS'(CODE_MIN_MS_RST * US_PER_MS);
  localparam logic [THR_BITS-1:0] CODE_HI_RST =
    THR_BITS'((CODE_MAX_MS_RST + 1) * US_PER_MS);
  localparam logic [THR_BITS-1:0] TMO_RST =
    THR_BITS'((TIMEOUT_MS_RST + 1) * US_PER_MS);

  // ms value to lowest microsecond count that reaches it after truncation
  function automatic logic [THR_BITS-1:0] ms_to_lo(input logic [CFG_BITS-1:0] ms);
    return THR_BITS'(ms) * THR_BITS'(US_PER_MS);
  endfunction

  // ms value to first microsecond count beyond it after truncation
  function automatic logic [THR_BITS-1:0] ms_to_hi(input logic [CFG_BITS-1:0] ms);
    return (THR_BITS'(ms) + THR_BITS'(1)) * THR_BITS'(US_PER_MS);
  endfunction

  // thresholds kept in microseconds so no divide is needed
  logic [THR_BITS-1:0]  start_lo_r, start_hi_r, code_lo_r, code_hi_r, tmo_r;
  logic [CODE_BITS-1:0] highest_r;

  // decoder state
  logic                  in_seq_r, in_seq_nxt;
  logic [TIME_BITS-1:0]  fall_time_r, fall_time_nxt;
  logic [TIME_BITS-1:0]  last_time_r, last_time_nxt;
  logic [COUNT_BITS-1:0] tally_r, tally_nxt;

  // input register
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_opcode_r, s1_level_r;
  logic [TIME_BITS-1:0] s1_time_r;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0] out_error_code_r, out_error_code_nxt;
  logic                 out_well_formed_r, out_well_formed_nxt;

  logic                 in_accept, fire, emit;
  logic [TIME_BITS-1:0] diff_fall, diff_last;
  logic [CMP_BITS-1:0]  df_ext, dl_ext;
  logic                 start_ok, code_ok, timed_out, good;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_lo_r <= START_LO_RST;
      start_hi_r <= START_HI_RST;
      code_lo_r  <= CODE_LO_RST;
      code_hi_r  <= CODE_HI_RST;
      tmo_r      <= TMO_RST;
      highest_r  <= CODE_BITS'(HIGHEST_CODE_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MIN:    start_lo_r <= ms_to_lo(cfg_data);
        CFG_START_MAX:    start_hi_r <= ms_to_hi(cfg_data);
        CFG_CODE_MIN:     code_lo_r  <= ms_to_lo(cfg_data);
        CFG_CODE_MAX:     code_hi_r  <= ms_to_hi(cfg_data);
        CFG_TIMEOUT:      tmo_r      <= ms_to_hi(cfg_data);
        CFG_HIGHEST_CODE: highest_r  <= cfg_data[CODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input stage drains unless a full output register is stalled
  assign fire      = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  // window and timeout compares on wrapped differences
  assign diff_fall = s1_time_r - fall_time_r;
  assign diff_last = s1_time_r - last_time_r;
  assign df_ext    = CMP_BITS'(diff_fall);
  assign dl_ext    = CMP_BITS'(diff_last);
  assign start_ok  = (df_ext >= CMP_BITS'(start_lo_r)) && (df_ext < CMP_BITS'(start_hi_r));
  assign code_ok   = (df_ext >= CMP_BITS'(code_lo_r)) && (df_ext < CMP_BITS'(code_hi_r));
  assign timed_out = dl_ext >= CMP_BITS'(tmo_r);

  // tally validity
  assign good = (tally_r != '0) && (CNT_CMP'(tally_r) <= CNT_CMP'(highest_r));

  // decode one transaction
  always_comb begin
    in_seq_nxt    = in_seq_r;
    fall_time_nxt = fall_time_r;
    last_time_nxt = last_time_r;
    tally_nxt     = tally_r;
    emit          = 1'b0;
    if (fire) begin
      case (s1_opcode_r)
        OP_EDGE: begin
          if (s1_level_r == LVL_FALL) begin
            fall_time_nxt = s1_time_r;
          end else if (!in_seq_r) begin
            if (start_ok) begin
              in_seq_nxt    = 1'b1;
              tally_nxt     = '0;
              last_time_nxt = s1_time_r;
            end
          end else if (code_ok) begin
            if (tally_r != '1) tally_nxt = tally_r + COUNT_BITS'(1);
            last_time_nxt = s1_time_r;
          end
        end
        OP_POLL: begin
          if (in_seq_r && timed_out) begin
            emit       = 1'b1;
            in_seq_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // result register next values
  always_comb begin
    out_valid_nxt       = (out_valid_r && out_stall) || emit;
    out_error_code_nxt  = out_error_code_r;
    out_well_formed_nxt = out_well_formed_r;
    if (emit) begin
      out_error_code_nxt  = good ? CODE_BITS'(tally_r) : '0;
      out_well_formed_nxt = good;
    end
  end

  assign s1_valid_nxt = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      in_seq_r    <= 1'b0;
      fall_time_r <= '0;
      last_time_r <= '0;
      tally_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      in_seq_r    <= in_seq_nxt;
      fall_time_r <= fall_time_nxt;
      last_time_r <= last_time_nxt;
      tally_r     <= tally_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode_r <= in_opcode;
      s1_level_r  <= in_pin_level;
      s1_time_r   <= in_time_us;
    end
    out_error_code_r  <= out_error_code_nxt;
    out_well_formed_r <= out_well_formed_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_error_code  = out_error_code_r;
  assign out_well_formed = out_well_formed_r;

  // checks
`include "pulse_width_error_code_decoder_macros.svh"

  `PWECD_ASSERT_NEXT(a_emit_goes_idle, emit, !in_seq_r, "sequence still open after result")
  `PWECD_ASSERT_NOW(a_malformed_zero, out_valid_r && !out_well_formed_r,
    out_error_code_r == '0, "malformed result carries a nonzero code")
  `PWECD_ASSERT_NOW(a_good_nonzero, out_valid_r && out_well_formed_r,
    out_error_code_r != '0, "well formed result carries code zero")

endmodule
